// File: sv/rcct_pkg.sv
// shared types, constants and helpers of the raycast column texturer
package rcct_pkg;

    localparam int DIST_W     = 26;
    localparam int FRAC_W     = 16;
    localparam int FACE_W     = 2;
    localparam int COLUMN_W   = 10;
    localparam int ROW_OUT_W  = 9;
    localparam int REGION_W   = 2;
    localparam int TEXIDX_W   = 6;
    localparam int TEXEL_W    = 22;
    localparam int COLOR_W    = 32;
    localparam int DEST_W     = 25;
    localparam int HEIGHT_W   = 16;
    localparam int STRIDE_W   = 16;
    localparam int FACTOR_W   = 15;
    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hFFFF;
    localparam logic [FACE_W-1:0]   FACE_SOUTH = 2'd2;

    localparam logic [REGION_W-1:0] REGION_CEILING = 2'd0;
    localparam logic [REGION_W-1:0] REGION_WALL    = 2'd1;
    localparam logic [REGION_W-1:0] REGION_FLOOR   = 2'd2;

    localparam logic MODE_SETUP = 1'b0;
    localparam logic MODE_ROW   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN_OUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_STRIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_STRIDE = 3'd4;

    localparam logic [STRIDE_W-1:0] FRAME_STRIDE_RST   = 16'd4096;
    localparam logic [STRIDE_W-1:0] TEXTURE_STRIDE_RST = 16'd256;

    typedef struct packed {
        logic                mode;
        logic [DIST_W-1:0]   wall_dist;
        logic [FRAC_W-1:0]   hit_frac;
        logic [FACE_W-1:0]   face;
        logic [COLUMN_W-1:0] column;
    } item_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [REGION_W-1:0]  region;
        logic [TEXIDX_W-1:0]  tex_row;
        logic [TEXIDX_W-1:0]  tex_col;
        logic [FACE_W-1:0]    wall_face;
        logic [TEXEL_W-1:0]   texel_offset;
        logic [COLOR_W-1:0]   pixel_bytes;
        logic [DEST_W-1:0]    dest_offset;
        logic                 last;
    } pixel_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_H,
        ST_DIV_S,
        ST_POS,
        ST_POS_WR,
        ST_ROW_A,
        ST_ROW_B,
        ST_ROW_C
    } state_t;

    function automatic logic [COLOR_W-1:0] byte_swap(input logic [COLOR_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// File: sv/rcct_stream_if.sv
// valid/ready stream channel carrying one payload struct
interface rcct_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/rcct_div.sv
// iterative restoring divider, one quotient bit per cycle
module rcct_div
    import rcct_pkg::*;
#(
    parameter int NUM_W = 27,
    parameter int DEN_W = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output div_status_t      status
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    // shift next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
    end

    assign quo         = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: sv/rcct_mul.sv
// shared unsigned multiplier with registered product
module rcct_mul
    import rcct_pkg::*;
#(
    parameter int A_W = 16,
    parameter int B_W = 23
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] product
);

    logic [A_W+B_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    assign product = product_reg;

endmodule

// File: sv/raycast_column_texturer.sv
// top level of the textured raycaster wall column generator
//
// A setup transfer (mode 0) latches one ray hit and runs two divisions on one shared
// restoring divider, one quotient bit per cycle: the wall height ROWS*2^16/dist
// (saturating at 0xFFFF) and then the texture step TEX*2^16/height, followed by one pass
// through the shared multiplier for the starting texture position. The dividend width
// NUM_W is 26 for ROWS=512, TEX=64. A zero height skips the second division and the
// multiplier pass. A row transfer (mode 1) steps through ROW_A, ROW_B and ROW_C, with
// two passes through the shared multiplier (frame offset, then texel offset); the pixel
// is registered at the end of ROW_C once the output register is free, and the next input
// is taken once the sequencer is back in idle; ROW_C waits while the previous pixel is
// still unread. Row transfers past the last row give no pixel and leave the block idle.
// The input is taken only while the sequencer is idle, and a finished pixel waits in an
// output register, so a new input can be taken while that pixel is still unread.
// Configuration writes are to be made only while the block is idle; the block itself
// does not enforce this.
module raycast_column_texturer
    import rcct_pkg::*;
#(
    parameter int ROWS = 512,
    parameter int TEX  = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rcct_stream_if.sink           item,
    rcct_stream_if.source         pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // widths derived from the screen height and texture size
    localparam int CNT_W      = $clog2(ROWS + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int HALF_ROWS  = ROWS / 2;
    localparam int TC_W       = $clog2(TEX);
    localparam int TXB        = $clog2(TEX + 1);
    localparam int STEP_W     = TXB + 16;
    localparam int H_NUM_W    = $clog2(ROWS + 1) + 16;
    localparam int NUM_W      = (H_NUM_W > STEP_W) ? H_NUM_W : STEP_W;
    localparam int MUL_A_W    = 16;
    localparam int MUL_B_W    = (STEP_W > 16) ? STEP_W : 16;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int FRAC_P_W   = FRAC_W + TXB;

    localparam logic [NUM_W-1:0]    NUM_HEIGHT = NUM_W'(ROWS) << 16;
    localparam logic [NUM_W-1:0]    NUM_STEP   = NUM_W'(TEX) << 16;
    localparam logic [CNT_W-1:0]    ROWS_CNT   = CNT_W'(ROWS);
    localparam logic [CNT_W-1:0]    LAST_ROW   = CNT_W'(ROWS - 1);
    localparam logic [HEIGHT_W-1:0] HALF_ROWS_H = HEIGHT_W'(HALF_ROWS);
    localparam logic [TC_W-1:0]     TEX_MAX    = TC_W'(TEX - 1);

    // configuration registers
    logic [COLOR_W-1:0]  ceiling_color_reg;
    logic [COLOR_W-1:0]  floor_color_reg;
    logic                big_endian_out_reg;
    logic [STRIDE_W-1:0] frame_stride_reg;
    logic [STRIDE_W-1:0] texture_stride_reg;

    // per column state
    state_t              state_reg;
    state_t              state_next;
    logic [COLUMN_W-1:0] col_reg;
    logic [FACE_W-1:0]   face_reg;
    logic [TC_W-1:0]     tex_col_reg;
    logic [HEIGHT_W-1:0] wall_height_reg;
    logic [ROW_W-1:0]    wall_start_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [STEP_W-1:0]   tex_step_reg;
    logic [POS_W-1:0]    tex_pos_reg;
    logic [CNT_W-1:0]    row_count_reg;
    logic [DEST_W-1:0]   dest_part_reg;

    // output register
    logic                out_valid_reg;
    pixel_t              out_data_reg;
    pixel_t              out_data_next;

    // handshake and sequencing
    logic                in_fire;
    logic                out_free;
    logic                out_load;
    logic                row_open;

    // shared divider
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DIST_W-1:0]   div_den;
    logic [NUM_W-1:0]    div_quo;
    div_status_t         div_stat;

    // shared multiplier
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;

    // setup datapath
    logic                h_sat;
    logic [HEIGHT_W-1:0] h_next;
    logic [HEIGHT_W-1:0] half_h;
    logic                half_over;
    logic [FRAC_P_W-1:0] frac_prod;
    logic [TC_W-1:0]     tc_raw;
    logic [TC_W-1:0]     tc_next;

    // row datapath
    logic [HEIGHT_W:0]   wall_end;
    logic [HEIGHT_W:0]   y_ext;
    logic                in_ceiling;
    logic                in_floor;
    logic [TC_W-1:0]     trow;
    logic [COLOR_W-1:0]  color;

    assign in_fire  = item.valid && item.ready;
    assign out_free = !out_valid_reg || pixel.ready;
    assign row_open = row_count_reg < ROWS_CNT;

    rcct_div #(
        .NUM_W (NUM_W),
        .DEN_W (DIST_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quo    (div_quo),
        .status (div_stat)
    );

    rcct_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // wall height from the first division, saturated
    assign h_sat     = |div_quo[NUM_W-1:16];
    assign h_next    = h_sat ? HEIGHT_MAX : div_quo[HEIGHT_W-1:0];
    assign half_h    = {1'b0, h_next[HEIGHT_W-1:1]};
    assign half_over = half_h >= HALF_ROWS_H;

    // texture column, mirrored on every face but south
    assign frac_prod = FRAC_P_W'(item.data.hit_frac) * FRAC_P_W'(TEX);
    assign tc_raw    = frac_prod[16 +: TC_W];
    assign tc_next   = (item.data.face != FACE_SOUTH) ? TEX_MAX - tc_raw : tc_raw;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (item.data.mode == MODE_SETUP)
                        state_next = ST_DIV_H;
                    else if (row_open)
                        state_next = ST_ROW_A;
                end
            end
            ST_DIV_H:
            begin
                if (div_stat.done)
                    state_next = (h_next == '0) ? ST_IDLE : ST_DIV_S;
            end
            ST_DIV_S:
            begin
                if (div_stat.done)
                    state_next = ST_POS;
            end
            ST_POS:    state_next = ST_POS_WR;
            ST_POS_WR: state_next = ST_IDLE;
            ST_ROW_A:  state_next = ST_ROW_B;
            ST_ROW_B:  state_next = ST_ROW_C;
            ST_ROW_C:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, divider start, operand selection
    always_comb
    begin
        item.ready = 1'b0;
        div_start  = 1'b0;
        div_num    = NUM_STEP;
        div_den    = DIST_W'(h_next);
        mul_a      = texture_stride_reg;
        mul_b      = MUL_B_W'(trow);
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                div_num    = NUM_HEIGHT;
                div_den    = item.data.wall_dist;
                div_start  = in_fire && (item.data.mode == MODE_SETUP);
            end
            ST_DIV_H:
            begin
                div_start = div_stat.done && (h_next != '0);
            end
            ST_POS:
            begin
                mul_a = MUL_A_W'(factor_reg);
                mul_b = MUL_B_W'(tex_step_reg);
            end
            ST_ROW_A:
            begin
                mul_a = frame_stride_reg;
                mul_b = MUL_B_W'(row_count_reg);
            end
            ST_ROW_C:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // region of the current row and clamped texture row
    assign y_ext      = (HEIGHT_W+1)'(row_count_reg);
    assign wall_end   = (HEIGHT_W+1)'(wall_start_reg) + (HEIGHT_W+1)'(wall_height_reg);
    assign in_ceiling = y_ext < (HEIGHT_W+1)'(wall_start_reg);
    assign in_floor   = y_ext >= wall_end;
    assign trow       = (tex_pos_reg[POS_W-1:16] > HEIGHT_W'(TEX - 1)) ? TEX_MAX
                      : tex_pos_reg[16 +: TC_W];
    assign color      = in_ceiling ? ceiling_color_reg : floor_color_reg;

    // pixel assembly; the multiplier holds the texel row product here
    always_comb
    begin
        out_data_next              = '0;
        out_data_next.row          = ROW_OUT_W'(row_count_reg);
        out_data_next.wall_face    = face_reg;
        out_data_next.dest_offset  = dest_part_reg + DEST_W'({col_reg, 2'b00});
        out_data_next.last         = row_count_reg == LAST_ROW;
        if (in_ceiling || in_floor)
        begin
            out_data_next.region      = in_ceiling ? REGION_CEILING : REGION_FLOOR;
            out_data_next.pixel_bytes = big_endian_out_reg ? byte_swap(color) : color;
        end
        else
        begin
            out_data_next.region       = REGION_WALL;
            out_data_next.tex_row      = TEXIDX_W'(trow);
            out_data_next.tex_col      = TEXIDX_W'(tex_col_reg);
            out_data_next.texel_offset = mul_p[TEXEL_W-1:0] + TEXEL_W'({tex_col_reg, 2'b00});
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_color_reg  <= '0;
            floor_color_reg    <= '0;
            big_endian_out_reg <= 1'b0;
            frame_stride_reg   <= FRAME_STRIDE_RST;
            texture_stride_reg <= TEXTURE_STRIDE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CEILING_COLOR:  ceiling_color_reg  <= cfg_data;
                REG_FLOOR_COLOR:    floor_color_reg    <= cfg_data;
                REG_BIG_ENDIAN_OUT: big_endian_out_reg <= cfg_data[0];
                REG_FRAME_STRIDE:   frame_stride_reg   <= cfg_data[STRIDE_W-1:0];
                REG_TEXTURE_STRIDE: texture_stride_reg <= cfg_data[STRIDE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // column state and sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            col_reg         <= '0;
            face_reg        <= '0;
            tex_col_reg     <= '0;
            wall_height_reg <= '0;
            wall_start_reg  <= '0;
            factor_reg      <= '0;
            tex_step_reg    <= '0;
            tex_pos_reg     <= '0;
            row_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // setup transfer: latch the hit and restart the column
            if (state_reg == ST_IDLE && in_fire && item.data.mode == MODE_SETUP)
            begin
                col_reg       <= item.data.column;
                face_reg      <= item.data.face;
                tex_col_reg   <= tc_next;
                row_count_reg <= '0;
            end

            // height known: centre the wall, clamp the start at the top row
            if (state_reg == ST_DIV_H && div_stat.done)
            begin
                wall_height_reg <= h_next;
                wall_start_reg  <= half_over ? '0 : ROW_W'(HALF_ROWS_H - half_h);
                factor_reg      <= half_over ? FACTOR_W'(half_h - HALF_ROWS_H) : '0;
                if (h_next == '0)
                begin
                    tex_step_reg <= '0;
                    tex_pos_reg  <= '0;
                end
            end

            if (state_reg == ST_DIV_S && div_stat.done)
                tex_step_reg <= div_quo[STEP_W-1:0];

            // skipped rows above the screen, in texture position units
            if (state_reg == ST_POS_WR)
                tex_pos_reg <= mul_p[POS_W-1:0];

            if (out_load)
            begin
                row_count_reg <= row_count_reg + 1'b1;
                if (!in_ceiling && !in_floor)
                    tex_pos_reg <= tex_pos_reg + POS_W'(tex_step_reg);
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pixel.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROW_B)
            dest_part_reg <= mul_p[DEST_W-1:0];
        if (out_load)
            out_data_reg <= out_data_next;
    end

    assign pixel.valid = out_valid_reg;
    assign pixel.data  = out_data_reg;

    // a new pixel only ever comes from the last row step
    a_pixel_from_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel.valid) |-> $past(state_reg) == ST_ROW_C)
        else $error("pixel appeared outside the row step");

    // the divider only runs while the sequencer waits on it
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV_H || state_reg == ST_DIV_S))
        else $error("divider busy outside a division state");

    // the row counter stops at the bottom of the screen
    a_row_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> row_count_reg <= ROWS_CNT && row_count_reg != '0)
        else $error("row counter out of range after a pixel");

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the raycast column texturer
module tb_top;
    import rcct_pkg::*;

    localparam int SCREEN_ROWS = 512;
    localparam int TEX_DIM     = 64;

    // face codes besides south, which comes from the package
    localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
    localparam logic [FACE_W-1:0] FACE_EAST  = 2'd1;
    localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

    // a setup runs two serial divisions and yields no pixel
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 100000;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rcct_stream_if #(.data_t(item_t))  item_ch ();
    rcct_stream_if #(.data_t(pixel_t)) pixel_ch ();

    raycast_column_texturer #(
        .ROWS (SCREEN_ROWS),
        .TEX  (TEX_DIM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .pixel     (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // transfers still to be offered, and pixels the column math says are due
    item_t  queued_items[$];
    pixel_t due_pixels[$];

    // shadow of the configuration registers
    logic [31:0]         ceil_color_q;
    logic [31:0]         floor_color_q;
    logic                swap_bytes_q;
    logic [STRIDE_W-1:0] frame_stride_q;
    logic [STRIDE_W-1:0] tex_stride_q;

    // shadow of the column state
    logic [COLUMN_W-1:0] col_q;
    logic [FACE_W-1:0]   face_q;
    logic [TEXIDX_W-1:0] tcol_q;
    logic [HEIGHT_W-1:0] height_q;
    logic [8:0]          start_q;
    logic [23:0]         step_q;
    logic [POS_W-1:0]    pos_q;
    logic [9:0]          row_q;

    int unsigned errors;
    int unsigned n_items;
    int unsigned n_setups;
    int unsigned n_pixels;
    int unsigned n_settings;
    int unsigned gen_row;

    // driver and monitor bookkeeping
    bit          in_flight;
    int unsigned gap_left;
    int unsigned stall_left;
    bit          drv_calm;
    bit          mon_calm;

    // ------------------------------------------------------------------
    // column math
    // ------------------------------------------------------------------

    // setup transfer: height, start row, texture column, step and start position
    function automatic void latch_ray(input item_t it);
        logic [63:0]         h;
        logic [HEIGHT_W-1:0] half_h;
        logic [31:0]         tc;
        logic [63:0]         offs;
        face_q = it.face;
        col_q  = it.column;
        if (it.wall_dist == '0)
        begin
            h = 64'(HEIGHT_MAX);
        end
        else
        begin
            h = (64'(SCREEN_ROWS) << 16) / 64'(it.wall_dist);
            if (h > 64'(HEIGHT_MAX))
            begin
                h = 64'(HEIGHT_MAX);
            end
        end
        height_q = h[HEIGHT_W-1:0];
        half_h   = height_q >> 1;
        // wall centred on the screen, top clamped at row 0
        if (32'(half_h) >= 32'(SCREEN_ROWS / 2))
        begin
            start_q = '0;
        end
        else
        begin
            start_q = 9'(32'(SCREEN_ROWS / 2) - 32'(half_h));
        end
        tc = (32'(it.hit_frac) * 32'(TEX_DIM)) >> 16;
        // every face but south reads the texture mirrored
        if (it.face != FACE_SOUTH)
        begin
            tc = 32'(TEX_DIM - 1) - tc;
        end
        tcol_q = tc[TEXIDX_W-1:0];
        if (height_q == '0)
        begin
            step_q = '0;
        end
        else
        begin
            step_q = 24'((64'(TEX_DIM) << 16) / 64'(height_q));
        end
        // skip the part of the wall cut off above row 0
        offs  = 64'(start_q) + 64'(half_h) - 64'(SCREEN_ROWS / 2);
        pos_q = 32'(offs * 64'(step_q));
        row_q = '0;
    endfunction

    // row transfer: next pixel of the column, none once the column is done
    function automatic bit next_pixel(output pixel_t px);
        logic [31:0] y;
        logic [31:0] color;
        logic [31:0] trow;
        logic [63:0] texel;
        logic [63:0] dest;
        px = '0;
        if (32'(row_q) >= 32'(SCREEN_ROWS))
        begin
            return 1'b0;
        end
        y = 32'(row_q);
        color = '0;
        px.wall_face = face_q;
        if (y < 32'(start_q))
        begin
            px.region = REGION_CEILING;
            color     = ceil_color_q;
        end
        else if (y >= 32'(start_q) + 32'(height_q))
        begin
            px.region = REGION_FLOOR;
            color     = floor_color_q;
        end
        else
        begin
            px.region = REGION_WALL;
            trow = pos_q >> 16;
            if (trow > 32'(TEX_DIM - 1))
            begin
                trow = 32'(TEX_DIM - 1);
            end
            px.tex_row = trow[TEXIDX_W-1:0];
            px.tex_col = tcol_q;
            texel = 64'(trow) * 64'(tex_stride_q) + 64'(tcol_q) * 64'd4;
            px.texel_offset = texel[TEXEL_W-1:0];
            pos_q = pos_q + 32'(step_q);
        end
        if (px.region != REGION_WALL)
        begin
            if (swap_bytes_q)
            begin
                px.pixel_bytes = {<<8{color}};
            end
            else
            begin
                px.pixel_bytes = color;
            end
        end
        dest = 64'(frame_stride_q) * 64'(y) + 64'(col_q) * 64'd4;
        px.dest_offset = dest[DEST_W-1:0];
        px.row  = y[ROW_OUT_W-1:0];
        px.last = (y == 32'(SCREEN_ROWS - 1));
        row_q = 10'(y + 1);
        return 1'b1;
    endfunction

    function automatic void account_item(input item_t it);
        pixel_t px;
        n_items++;
        if (it.mode == MODE_SETUP)
        begin
            latch_ray(it);
            n_setups++;
        end
        else if (next_pixel(px))
        begin
            due_pixels.push_back(px);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued transfers, random gap after each one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive
        item_t nxt;
        bit    hold;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            in_flight = 1'b0;
            gap_left  = 0;
            drv_calm  = 1'b0;
        end
        else
        begin
            hold = in_flight;
            if (item_ch.valid && item_ch.ready)
            begin
                account_item(item_ch.data);
                in_flight = 1'b0;
                hold = 1'b0;
            end
            if (!hold)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (queued_items.size() != 0)
                begin
                    nxt = queued_items.pop_front();
                    item_ch.data  <= nxt;
                    item_ch.valid <= 1'b1;
                    in_flight = 1'b1;
                    // now and then switch between gappy and back-to-back stretches
                    if (($urandom & 31) == 0)
                    begin
                        drv_calm = !drv_calm;
                    end
                    gap_left = drv_calm ? 0 : $urandom_range(0, 8);
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: takes pixels with random stalls and checks them in order
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            pixel_ch.ready <= 1'b0;
            stall_left = 0;
            mon_calm   = 1'b0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                got = pixel_ch.data;
                if (due_pixels.size() == 0)
                begin
                    $error("pixel transfer with none due: row 0x%0h", got.row);
                    errors++;
                end
                else
                begin
                    want = due_pixels.pop_front();
                    check_field("row", 32'(want.row), 32'(got.row));
                    check_field("region", 32'(want.region), 32'(got.region));
                    check_field("tex_row", 32'(want.tex_row), 32'(got.tex_row));
                    check_field("tex_col", 32'(want.tex_col), 32'(got.tex_col));
                    check_field("wall_face", 32'(want.wall_face), 32'(got.wall_face));
                    check_field("texel_offset", 32'(want.texel_offset),
                                32'(got.texel_offset));
                    check_field("pixel_bytes", want.pixel_bytes, got.pixel_bytes);
                    check_field("dest_offset", 32'(want.dest_offset), 32'(got.dest_offset));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
                n_pixels++;
                if (($urandom & 31) == 0)
                begin
                    mon_calm = !mon_calm;
                end
                stall_left = mon_calm ? 0 : $urandom_range(0, 8);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                pixel_ch.ready <= 1'b0;
            end
            else
            begin
                pixel_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // writes all five registers and the shadow copy, block must be idle
    task automatic configure(input logic [31:0] ceil_c, input logic [31:0] floor_c,
                             input logic swap, input logic [15:0] fstride,
                             input logic [15:0] tstride);
        write_reg(REG_CEILING_COLOR, ceil_c);
        write_reg(REG_FLOOR_COLOR, floor_c);
        write_reg(REG_BIG_ENDIAN_OUT, 32'(swap));
        write_reg(REG_FRAME_STRIDE, 32'(fstride));
        write_reg(REG_TEXTURE_STRIDE, 32'(tstride));
        ceil_color_q   = ceil_c;
        floor_color_q  = floor_c;
        swap_bytes_q   = swap;
        frame_stride_q = fstride;
        tex_stride_q   = tstride;
        n_settings++;
    endtask

    // hold off until every transfer is taken and every due pixel is back
    task automatic drain();
        int unsigned waited;
        waited = 0;
        while ((queued_items.size() != 0 || in_flight || due_pixels.size() != 0) &&
               waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_setup(input logic [DIST_W-1:0] wdist, input logic [FRAC_W-1:0] frac,
                              input logic [FACE_W-1:0] face, input logic [COLUMN_W-1:0] col);
        item_t it;
        it.mode      = MODE_SETUP;
        it.wall_dist = wdist;
        it.hit_frac  = frac;
        it.face      = face;
        it.column    = col;
        queued_items.push_back(it);
        gen_row = 0;
    endtask

    // row transfers carry junk in the fields they ignore
    task automatic push_rows(input int unsigned n, output int unsigned counted);
        item_t it;
        counted = 0;
        repeat (n)
        begin
            it.mode      = MODE_ROW;
            it.wall_dist = DIST_W'($urandom);
            it.hit_frac  = FRAC_W'($urandom);
            it.face      = FACE_W'($urandom);
            it.column    = COLUMN_W'($urandom);
            queued_items.push_back(it);
            if (gen_row < SCREEN_ROWS)
            begin
                counted++;
                gen_row++;
            end
        end
    endtask

    // distance classes: very near (saturated up to 512), tall, medium and anything at all
    task automatic push_random_setup();
        int unsigned          pick;
        logic [DIST_W-1:0]    wdist;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            wdist = DIST_W'($urandom_range(0, 1023));
        end
        else if (pick < 50)
        begin
            wdist = DIST_W'($urandom_range(32768, 196608));
        end
        else if (pick < 75)
        begin
            wdist = DIST_W'($urandom_range(196608, 4194304));
        end
        else
        begin
            wdist = DIST_W'($urandom);
        end
        push_setup(wdist, FRAC_W'($urandom), FACE_W'($urandom), COLUMN_W'($urandom));
    endtask

    // mostly setup followed by a run of rows, some setups abandoned at once
    task automatic random_columns(input int unsigned target);
        int unsigned made;
        int unsigned pick;
        int unsigned n;
        int unsigned got;
        made = 0;
        while (made < target)
        begin
            push_random_setup();
            made++;
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                n = 0;
            end
            else if (pick < 50)
            begin
                n = $urandom_range(1, 48);
            end
            else if (pick < 82)
            begin
                n = $urandom_range(49, 300);
            end
            else
            begin
                n = $urandom_range(300, 530);
            end
            // keep the phase within its share of transfers
            if (n > target - made)
            begin
                n = target - made;
            end
            push_rows(n, got);
            made += got;
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        int unsigned got;
        int unsigned ph;
        errors     = 0;
        n_items    = 0;
        n_setups   = 0;
        n_pixels   = 0;
        n_settings = 0;
        gen_row    = 0;
        ceil_color_q   = '0;
        floor_color_q  = '0;
        swap_bytes_q   = 1'b0;
        frame_stride_q = FRAME_STRIDE_RST;
        tex_stride_q   = TEXTURE_STRIDE_RST;
        col_q    = '0;
        face_q   = '0;
        tcol_q   = '0;
        height_q = '0;
        start_q  = '0;
        step_q   = '0;
        pos_q    = '0;
        row_q    = '0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        item_ch.valid  = 1'b0;
        item_ch.data   = '0;
        pixel_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // rows before any setup use the reset column, all floor
        push_rows(3, got);
        drain();

        configure(32'h1122_3344, 32'hA1B2_C3D4, 1'b1, 16'hFFFF, 16'hFFFF);
        // zero distance saturates the height
        push_setup('0, 16'hFFFF, FACE_NORTH, 10'd1023);
        push_rows(3, got);
        // tiny distance also saturates, south face not mirrored
        push_setup(DIST_W'(1), 16'h0000, FACE_SOUTH, 10'd0);
        push_rows(2, got);
        // farthest distance gives zero height, no wall rows
        push_setup({DIST_W{1'b1}}, 16'h8000, FACE_EAST, 10'd512);
        push_rows(2, got);
        // distance 1.0 fills the screen exactly
        push_setup(DIST_W'(32'h1_0000), 16'h1234, FACE_WEST, 10'd5);
        push_rows(3, got);
        // distance 2.0 starts the wall a quarter down
        push_setup(DIST_W'(32'h2_0000), 16'hFFFF, FACE_SOUTH, 10'd700);
        push_rows(2, got);
        drain();

        for (ph = 0; ph < 5; ph++)
        begin
            if (ph == 0)
            begin
                configure('0, '0, 1'b0, '0, '0);
            end
            else if (ph == 4)
            begin
                configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'($urandom),
                          16'($urandom));
            end
            else
            begin
                configure($urandom, $urandom, 1'($urandom), 16'($urandom), 16'($urandom));
            end
            if (ph == 1)
            begin
                // one whole column and a few rows past its end
                push_random_setup();
                push_rows(SCREEN_ROWS + 4, got);
                random_columns(100);
            end
            else
            begin
                random_columns(150);
            end
            drain();
        end

        if (due_pixels.size() != 0)
        begin
            $error("%0d due pixels never came out", due_pixels.size());
            errors++;
        end
        $display("covered %0d input transfers with %0d column setups", n_items, n_setups);
        $display("checked %0d pixels over %0d register settings", n_pixels, n_settings);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
